// ===== sv/murmur2_64a_hash_unit_defines.svh =====
// assertion helpers shared by the hash unit modules
`ifndef MURMUR2_64A_HASH_UNIT_DEFINES_SVH
`define MURMUR2_64A_HASH_UNIT_DEFINES_SVH

// property must hold at every clock edge outside reset
`define MM64_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define MM64_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/mm64_pkg.sv =====
`default_nettype none

package mm64_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MUL_LO    = MIX_MUL[31:0];
  localparam logic [31:0] MUL_HI    = MIX_MUL[63:32];
  localparam int          MIX_SHIFT = 47;
  localparam logic [2:0]  TAIL_MASK = 3'h7;
  localparam logic [3:0]  FULL_BYTES = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // partial product passes of the shared multiplier
  localparam int          PHASE_W  = 2;
  localparam logic [PHASE_W-1:0] PHASE_LL = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_LH = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_HL = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TAIL = 2'd1,
    KIND_FULL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [63:0] word;
    kind_t       kind;
    logic        last;
    logic        first;
    logic [31:0] len;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] tail_mask(input logic [2:0] nbytes);
    logic [63:0] mask;
    mask = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < nbytes) begin
        mask[8*i +: 8] = 8'hff;
      end
    end
    return mask;
  endfunction

  function automatic logic [63:0] xorshift(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

`default_nettype wire

// ===== sv/mm64_front.sv =====
`default_nettype none

module mm64_front import mm64_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [63:0] data_word,
  input  wire logic [3:0]  valid_bytes,
  input  wire logic        last,
  input  wire logic [31:0] message_length,
  input  wire logic        q_full,
  output logic             enq,
  output entry_t           entry
);

  logic       at_start;
  logic [2:0] tail_bytes;

  assign enq        = push && !q_full;
  assign tail_bytes = valid_bytes[2:0] & TAIL_MASK;

  always_comb begin
    entry.last  = last;
    entry.first = at_start;
    entry.len   = message_length;
    entry.word  = data_word;
    if (valid_bytes == 4'd0) begin
      entry.kind = KIND_NONE;
    end else if (valid_bytes >= FULL_BYTES) begin
      entry.kind = KIND_FULL;
    end else begin
      entry.kind = KIND_TAIL;
      entry.word = data_word & tail_mask(tail_bytes);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (enq) begin
      at_start <= last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mm64_queue.sv =====
`default_nettype none
`include "murmur2_64a_hash_unit_defines.svh"

module mm64_queue import mm64_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   enq,
  input  wire entry_t enq_entry,
  output logic        q_full,
  input  wire logic   deq,
  output logic        q_empty,
  output entry_t      head
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign head    = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (deq) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (enq && !deq) begin
        count <= count + QCNT_W'(1);
      end else if (deq && !enq) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= enq_entry;
    end
  end

  `MM64_NEVER(a_q_deq_empty, deq && q_empty, "queue read while empty")
  `MM64_NEVER(a_q_enq_full, enq && q_full, "queue written while full")

endmodule

`default_nettype wire

// ===== sv/mm64_mul.sv =====
`default_nettype none
`include "murmur2_64a_hash_unit_defines.svh"

module mm64_mul import mm64_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic               running;
  logic [PHASE_W-1:0] phase;
  logic               done;
  logic [63:0]        x;
  logic [63:0]        prod;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        p;

  // low 64 bits of x * MIX_MUL from three 32x32 partial products
  assign mul_a = (phase == PHASE_HL) ? x[63:32] : x[31:0];
  assign mul_b = (phase == PHASE_LH) ? MUL_HI : MUL_LO;
  assign p     = mul_a * mul_b;

  assign rsp.done    = done;
  assign rsp.product = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      phase   <= PHASE_LL;
      done    <= 1'b0;
    end else begin
      done <= running && (phase == PHASE_HL);
      if (req.start) begin
        running <= 1'b1;
        phase   <= PHASE_LL;
      end else if (running) begin
        phase <= phase + PHASE_W'(1);
        if (phase == PHASE_HL) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= req.operand;
    end
    if (running) begin
      case (phase) inside
        PHASE_LL: prod <= p;
        PHASE_LH, PHASE_HL: prod[63:32] <= prod[63:32] + p[31:0];
        default: prod <= prod;
      endcase
    end
  end

  `MM64_NEVER(a_mul_start_busy, req.start && running, "multiply started while busy")

endmodule

`default_nettype wire

// ===== sv/mm64_back.sv =====
`default_nettype none
`include "murmur2_64a_hash_unit_defines.svh"

module mm64_back import mm64_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  wire entry_t      q_head,
  output logic             q_pop,
  output mul_req_t         mreq,
  input  wire mul_rsp_t    mrsp,
  input  wire logic        pop,
  output logic             out_valid,
  output logic [63:0]      hash_value
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SEED = 7'b0000010,
    ST_MIXA = 7'b0000100,
    ST_MIXB = 7'b0001000,
    ST_HMUL = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic [63:0] hash, hash_next;
  logic [63:0] result, result_next;
  entry_t      ent, ent_next;
  logic        out_valid_next;
  logic [63:0] hash_value_next;

  entry_t      disp_ent;
  logic [63:0] disp_h;
  state_t      disp_state;
  logic        disp_start;
  logic [63:0] disp_operand;
  logic        waiting;

  // pick the first multiply of an item once the running hash is known
  assign disp_ent = (state == ST_IDLE) ? q_head : ent;
  assign disp_h   = (state == ST_IDLE) ? hash : mrsp.product;

  assign waiting = state inside {ST_SEED, ST_MIXA, ST_MIXB, ST_HMUL, ST_FIN};

  always_comb begin
    disp_start   = 1'b0;
    disp_operand = disp_h;
    disp_state   = ST_IDLE;
    unique case (disp_ent.kind)
      KIND_FULL: begin
        disp_start   = 1'b1;
        disp_operand = disp_ent.word;
        disp_state   = ST_MIXA;
      end
      KIND_TAIL: begin
        disp_start   = 1'b1;
        disp_operand = disp_h ^ disp_ent.word;
        disp_state   = ST_HMUL;
      end
      KIND_NONE: begin
        if (disp_ent.last) begin
          disp_start   = 1'b1;
          disp_operand = xorshift(disp_h);
          disp_state   = ST_FIN;
        end
      end
      default: disp_state = ST_IDLE;
    endcase
  end

  always_comb begin
    state_next      = state;
    hash_next       = hash;
    result_next     = result;
    ent_next        = ent;
    q_pop           = 1'b0;
    mreq.start      = 1'b0;
    mreq.operand    = disp_operand;
    out_valid_next  = out_valid && !pop;
    hash_value_next = hash_value;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          ent_next = q_head;
          if (q_head.first) begin
            mreq.start   = 1'b1;
            mreq.operand = {32'd0, q_head.len};
            state_next   = ST_SEED;
          end else begin
            mreq.start = disp_start;
            state_next = disp_state;
          end
        end
      end
      ST_SEED: begin
        if (mrsp.done) begin
          hash_next  = mrsp.product;
          mreq.start = disp_start;
          state_next = disp_state;
        end
      end
      ST_MIXA: begin
        if (mrsp.done) begin
          mreq.start   = 1'b1;
          mreq.operand = xorshift(mrsp.product);
          state_next   = ST_MIXB;
        end
      end
      ST_MIXB: begin
        if (mrsp.done) begin
          mreq.start   = 1'b1;
          mreq.operand = hash ^ mrsp.product;
          state_next   = ST_HMUL;
        end
      end
      ST_HMUL: begin
        if (mrsp.done) begin
          hash_next = mrsp.product;
          if (ent.last) begin
            mreq.start   = 1'b1;
            mreq.operand = xorshift(mrsp.product);
            state_next   = ST_FIN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (mrsp.done) begin
          result_next = xorshift(mrsp.product);
          state_next  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || pop) begin
          out_valid_next  = 1'b1;
          hash_value_next = result;
          hash_next       = '0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      hash      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hash      <= hash_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ent        <= ent_next;
    result     <= result_next;
    hash_value <= hash_value_next;
  end

  `MM64_ASSERT(a_done_when_waiting, mrsp.done |-> waiting, "multiply done while not waiting")

endmodule

`default_nettype wire

// ===== sv/murmur2_64a_hash_unit.sv =====
`default_nettype none
// channel   handshake      payload
// input     push / full    data_word, valid_bytes, last, message_length
// result    pop / empty    hash_value
//
// each 64-bit product comes from one shared 32x32 multiplier (three passes)
// a full word runs mix and hash multiplies, a tail word only the hash one, empty none;
// a first word adds the length seed, a last word finalization and the output write
// a 2-item queue sits in front of the engine, so push is taken while a word is mixed
// a waiting result holds the engine only at the output write of the next message
// rst is synchronous: queue, engine and result register come up empty

module murmur2_64a_hash_unit import mm64_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [63:0] data_word,
  input  wire logic [3:0]  valid_bytes,
  input  wire logic        last,
  input  wire logic [31:0] message_length,
  input  wire logic        pop,
  output logic             empty,
  output logic [63:0]      hash_value
);

  logic     enq;
  entry_t   enq_entry;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  entry_t   q_head;
  mul_req_t mreq;
  mul_rsp_t mrsp;
  logic     out_valid;

  assign full  = q_full;
  assign empty = !out_valid;

  mm64_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .last           (last),
    .message_length (message_length),
    .q_full         (q_full),
    .enq            (enq),
    .entry          (enq_entry)
  );

  mm64_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq       (enq),
    .enq_entry (enq_entry),
    .q_full    (q_full),
    .deq       (q_pop),
    .q_empty   (q_empty),
    .head      (q_head)
  );

  mm64_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  mm64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .mreq       (mreq),
    .mrsp       (mrsp),
    .pop        (pop),
    .out_valid  (out_valid),
    .hash_value (hash_value)
  );

endmodule

`default_nettype wire

// ===== tb/murmur_hash_checker.sv =====
module murmur_hash_checker
  import mm64_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic        last,
  input  logic [31:0] message_length,
  input  logic        pop,
  input  logic        empty,
  input  logic [63:0] hash_value,
  output int          mismatches,
  output int          hashes_pending
);

  logic [63:0] running_hash;
  logic        msg_start;
  logic [63:0] expected_hashes[$];
  int          mismatch_count;

  initial begin
    mismatches     = 0;
    hashes_pending = 0;
    mismatch_count = 0;
    running_hash   = '0;
    msg_start      = 1'b1;
  end

  always @(posedge clk) begin
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] want;
    logic [3:0]  nbytes;
    if (rst) begin
      running_hash = '0;
      msg_start    = 1'b1;
      expected_hashes.delete();
    end else begin
      // compare the hash taken at this edge with the oldest prediction
      if (pop && !empty) begin
        if (expected_hashes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected hash %h with nothing expected", hash_value);
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("hash mismatch: expected %h got %h", want, hash_value);
          end
        end
      end
      // advance the running hash with the item taken at this edge
      if (push && !full) begin
        nbytes = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
        h = msg_start ? {32'h0, message_length} * MIX_MUL : running_hash;
        if (nbytes == FULL_BYTES) begin
          k = data_word * MIX_MUL;
          k ^= k >> MIX_SHIFT;
          k = k * MIX_MUL;
          h ^= k;
          h = h * MIX_MUL;
        end else if (nbytes != 4'd0) begin
          h ^= data_word & ((64'd1 << {nbytes, 3'b000}) - 64'd1);
          h = h * MIX_MUL;
        end
        if (last) begin
          h ^= h >> MIX_SHIFT;
          h = h * MIX_MUL;
          h ^= h >> MIX_SHIFT;
          expected_hashes.push_back(h);
          running_hash = '0;
          msg_start    = 1'b1;
        end else begin
          running_hash = h;
          msg_start    = 1'b0;
        end
      end
    end
    mismatches     <= mismatch_count;
    hashes_pending <= expected_hashes.size();
  end

endmodule

// ===== tb/tb_murmur2_64a_hash_unit.sv =====
module tb_murmur2_64a_hash_unit;
  import mm64_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 245;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        push           = 1'b0;
  logic        pop            = 1'b0;
  logic [63:0] data_word      = '0;
  logic [3:0]  valid_bytes    = '0;
  logic        last           = 1'b0;
  logic [31:0] message_length = '0;
  logic        full;
  logic        empty;
  logic [63:0] hash_value;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_items    = 0;
  int mismatches;
  int hashes_pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  murmur2_64a_hash_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .last           (last),
    .message_length (message_length),
    .pop            (pop),
    .empty          (empty),
    .hash_value     (hash_value)
  );

  murmur_hash_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .last           (last),
    .message_length (message_length),
    .pop            (pop),
    .empty          (empty),
    .hash_value     (hash_value),
    .mismatches     (mismatches),
    .hashes_pending (hashes_pending)
  );

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic put_word(input logic [63:0] w, input logic [3:0] nbytes,
                          input logic is_last, input logic [31:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push           <= 1'b1;
    data_word      <= w;
    valid_bytes    <= nbytes;
    last           <= is_last;
    message_length <= len;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_items++;
  endtask

  // well-formed message: full words, then a tail or an empty closing word unless a full word closes it
  task automatic put_message(input int nbytes, input bit pad_empty);
    int nfull;
    nfull = nbytes / 8;
    for (int i = 0; i < nfull; i++) begin
      put_word(random_word(), FULL_BYTES,
               (i == nfull - 1) && (nbytes % 8 == 0) && !pad_empty,
               (i == 0) ? 32'(nbytes) : $urandom);
    end
    if ((nbytes % 8 != 0) || (nfull == 0) || pad_empty)
      put_word(random_word(), 4'(nbytes % 8), 1'b1,
               (nfull == 0) ? 32'(nbytes) : $urandom);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (hashes_pending != 0) @(posedge clk);
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int target;
    int nbytes;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty message and extreme words
    put_word(64'h0, 4'd0, 1'b1, 32'h0);
    put_word('1, FULL_BYTES, 1'b1, 32'hffff_ffff);
    put_word(64'h0, FULL_BYTES, 1'b1, 32'd8);
    for (int n = 1; n < 8; n++) begin
      put_word('1, 4'(n), 1'b1, 32'(n));
    end
    // counts above eight act as a full word
    put_word('1, 4'd9, 1'b1, 32'd8);
    put_word(64'h0123_4567_89ab_cdef, 4'd15, 1'b1, 32'h0);
    // partial word inside a message
    put_word(64'hfedc_ba98_7654_3210, 4'd3, 1'b0, 32'd16);
    put_word(64'h5555_aaaa_5555_aaaa, FULL_BYTES, 1'b1, 32'h0);
    // length disagreeing with the words, closed by an empty word
    put_word(64'haaaa_5555_aaaa_5555, FULL_BYTES, 1'b0, 32'd5);
    put_word(64'h8000_0000_0000_0001, FULL_BYTES, 1'b0, 32'h8000_0000);
    put_word(64'h7fff_ffff_ffff_fffe, 4'd0, 1'b1, 32'h0);

    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        if ($urandom_range(99) < 15) begin
          put_word(random_word(), 4'($urandom_range(15)), $urandom_range(3) == 0, $urandom);
        end else begin
          nbytes = ($urandom_range(19) == 0) ? $urandom_range(64, 200) : $urandom_range(0, 40);
          put_message(nbytes, $urandom_range(7) == 0);
        end
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
